### rtl/bounded_stack_with_reverse_top_assert.svh
// Assertion macros used by the checker file bsr_checker.sv.
`ifndef BOUNDED_STACK_WITH_REVERSE_TOP_ASSERT_SVH
`define BOUNDED_STACK_WITH_REVERSE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bsr_pkg.sv
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH          = 3'd0,
        OP_POP           = 3'd1,
        OP_PEEK          = 3'd2,
        OP_INSERT_BOTTOM = 3'd3,
        OP_REVERSE       = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_LO,
        RD_HI,
        RD_PTR_DN
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_PUSH,
        WR_SHIFT,
        WR_BOTTOM,
        WR_LO,
        WR_HI
    } wr_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    ptr_init;
        logic    ptr_dec;
        logic    rev_init;
        logic    rev_step;
        logic    tmp_load;
        logic    res_load;
        logic    res_read;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    full;
        logic    cnt_gt1;
        logic    ptr_zero;
        logic    rev_more;
    } sts_t;

endpackage

### rtl/bsr_dp.sv
`timescale 1ns / 1ps

module bsr_dp #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [bsr_pkg::OP_W-1:0]           s_opcode,
    input  logic signed [bsr_pkg::DATA_W-1:0]  s_push_value,
    input  bsr_pkg::cmd_t                      cmd,
    output bsr_pkg::sts_t                      sts,
    output logic signed [bsr_pkg::DATA_W-1:0]  m_read_value,
    output logic [1:0]                         m_status,
    output logic                               m_is_empty,
    output logic                               m_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [bsr_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic signed [bsr_pkg::DATA_W-1:0] rdata_reg;
    logic signed [bsr_pkg::DATA_W-1:0] tmp_reg;
    logic signed [bsr_pkg::DATA_W-1:0] val_reg;
    bsr_pkg::opcode_t                  op_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [AW-1:0]                     ptr_reg;
    logic [AW-1:0]                     lo_reg;
    logic [AW-1:0]                     hi_reg;

    logic signed [bsr_pkg::DATA_W-1:0] m_read_value_reg;
    bsr_pkg::status_t                  m_status_reg;
    logic                              m_is_empty_reg;
    logic                              m_is_full_reg;

    logic [CW-1:0]                     count_m1;
    logic [AW-1:0]                     top_addr;
    logic [AW-1:0]                     rd_addr;
    logic [AW-1:0]                     wr_addr;
    logic signed [bsr_pkg::DATA_W-1:0] wr_data;
    logic                              cnt_zero;
    logic                              cnt_full;

    assign count_m1 = count_reg - CW'(1);
    assign top_addr = count_m1[AW-1:0];
    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == CW'(DEPTH));

    always_comb begin
        case (cmd.rd_sel)
            bsr_pkg::RD_TOP:    rd_addr = top_addr;
            bsr_pkg::RD_LO:     rd_addr = lo_reg;
            bsr_pkg::RD_HI:     rd_addr = hi_reg;
            bsr_pkg::RD_PTR_DN: rd_addr = ptr_reg - AW'(1);
            default:            rd_addr = top_addr;
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            bsr_pkg::WR_PUSH: begin
                wr_addr = count_reg[AW-1:0];
                wr_data = val_reg;
            end
            bsr_pkg::WR_SHIFT: begin
                wr_addr = ptr_reg + AW'(1);
                wr_data = rdata_reg;
            end
            bsr_pkg::WR_BOTTOM: begin
                wr_addr = '0;
                wr_data = val_reg;
            end
            bsr_pkg::WR_LO: begin
                wr_addr = lo_reg;
                wr_data = rdata_reg;
            end
            bsr_pkg::WR_HI: begin
                wr_addr = hi_reg;
                wr_data = tmp_reg;
            end
            default: begin
                wr_addr = '0;
                wr_data = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= bsr_pkg::opcode_t'(s_opcode);
            val_reg <= s_push_value;
        end
        if (cmd.tmp_load) begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.ptr_init) begin
            ptr_reg <= top_addr;
        end else if (cmd.ptr_dec) begin
            ptr_reg <= ptr_reg - AW'(1);
        end
        if (cmd.rev_init) begin
            lo_reg <= '0;
            hi_reg <= top_addr;
        end else if (cmd.rev_step) begin
            lo_reg <= lo_reg + AW'(1);
            hi_reg <= hi_reg - AW'(1);
        end
        if (cmd.res_load) begin
            m_read_value_reg <= cmd.res_read ? rdata_reg : '0;
            m_status_reg     <= cmd.res_status;
            m_is_empty_reg   <= cnt_zero;
            m_is_full_reg    <= cnt_full;
        end
    end

    assign sts.op       = op_reg;
    assign sts.empty    = cnt_zero;
    assign sts.full     = cnt_full;
    assign sts.cnt_gt1  = (count_reg > CW'(1));
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.rev_more = (({1'b0, lo_reg} + (AW + 1)'(2)) < {1'b0, hi_reg});

    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_is_empty   = m_is_empty_reg;
    assign m_is_full    = m_is_full_reg;

endmodule

### rtl/bsr_ctrl.sv
`timescale 1ns / 1ps

module bsr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  bsr_pkg::sts_t sts,
    output bsr_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        INS_MV,
        INS_BOT,
        REV_RD_LO,
        REV_RD_HI,
        REV_WR_LO,
        REV_WR_HI,
        FIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    bsr_pkg::status_t res_status_reg;
    bsr_pkg::status_t res_status_next;
    logic             res_read_reg;
    logic             res_read_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    always_comb begin
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_read    = res_read_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;

        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = DISPATCH;
                end
            end
            DISPATCH: begin
                res_status_next = bsr_pkg::ST_OK;
                res_read_next   = 1'b0;
                state_next      = FIN;
                unique case (sts.op) inside
                    bsr_pkg::OP_PUSH: begin
                        if (sts.full) begin
                            res_status_next = bsr_pkg::ST_OVERFLOW;
                        end else begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = bsr_pkg::WR_PUSH;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    bsr_pkg::OP_POP, bsr_pkg::OP_PEEK: begin
                        if (sts.empty) begin
                            res_status_next = bsr_pkg::ST_UNDERFLOW;
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = bsr_pkg::RD_TOP;
                            cmd.cnt_dec   = (sts.op == bsr_pkg::OP_POP);
                            res_read_next = 1'b1;
                        end
                    end
                    bsr_pkg::OP_INSERT_BOTTOM: begin
                        if (sts.full) begin
                            res_status_next = bsr_pkg::ST_OVERFLOW;
                        end else if (sts.empty) begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = bsr_pkg::WR_BOTTOM;
                            cmd.cnt_inc = 1'b1;
                        end else begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = bsr_pkg::RD_TOP;
                            cmd.ptr_init = 1'b1;
                            state_next   = INS_MV;
                        end
                    end
                    bsr_pkg::OP_REVERSE: begin
                        if (sts.cnt_gt1) begin
                            cmd.rev_init = 1'b1;
                            state_next   = REV_RD_LO;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            INS_MV: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bsr_pkg::WR_SHIFT;
                if (sts.ptr_zero) begin
                    state_next = INS_BOT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = bsr_pkg::RD_PTR_DN;
                    cmd.ptr_dec = 1'b1;
                end
            end
            INS_BOT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = bsr_pkg::WR_BOTTOM;
                cmd.cnt_inc = 1'b1;
                state_next  = FIN;
            end
            REV_RD_LO: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsr_pkg::RD_LO;
                state_next = REV_RD_HI;
            end
            REV_RD_HI: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = bsr_pkg::RD_HI;
                cmd.tmp_load = 1'b1;
                state_next   = REV_WR_LO;
            end
            REV_WR_LO: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bsr_pkg::WR_LO;
                state_next = REV_WR_HI;
            end
            REV_WR_HI: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = bsr_pkg::WR_HI;
                cmd.rev_step = 1'b1;
                state_next   = sts.rev_more ? REV_RD_LO : FIN;
            end
            FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            res_status_reg <= bsr_pkg::ST_OK;
            res_read_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_read_reg   <= res_read_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/bounded_stack_with_reverse_top.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words with push, pop, peek, insert at
// bottom and in-place reverse. Items enter on the s_ channel (opcode and
// push_value) and each item gives exactly one result on the m_ channel
// (read_value, status, is_empty, is_full), both with valid and ready.
// The block works on one item at a time; s_ready is high only when idle.
// Push, pop, peek, unknown codes, refused items and insert into an empty
// stack pass through DISPATCH to FIN; insert at bottom otherwise shifts each
// entry up one place before writing the bottom, and reverse swaps each pair
// of entries (read low, read high, write low, write high), since every move
// goes through the single read port and single write port of the entry memory.
// The next item may be accepted in the cycle after the result is registered.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; a finished item then holds until m_ready frees it.
// A synchronous low aresetn empties the stack and drops any pending result;
// the entry memory is not cleared, since only written entries are ever read.
module bounded_stack_with_reverse_top #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bsr_pkg::OP_W-1:0]           s_opcode,
    input  logic signed [bsr_pkg::DATA_W-1:0]  s_push_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bsr_pkg::DATA_W-1:0]  m_read_value,
    output logic [1:0]                         m_status,
    output logic                               m_is_empty,
    output logic                               m_is_full
);

    bsr_pkg::cmd_t cmd;
    bsr_pkg::sts_t sts;

    bsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .cmd          (cmd),
        .sts          (sts),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full)
    );

endmodule

### rtl/bsr_checker.sv
`timescale 1ns / 1ps
`include "bounded_stack_with_reverse_top_assert.svh"

module bsr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [bsr_pkg::OP_W-1:0]           s_opcode,
    input logic signed [bsr_pkg::DATA_W-1:0]  s_push_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [bsr_pkg::DATA_W-1:0]  m_read_value,
    input logic [1:0]                         m_status,
    input logic                               m_is_empty,
    input logic                               m_is_full
);

    `BSR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_status), "Result item changed while stalled")
    `BSR_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "Second item accepted while one is in work")
    `BSR_ASSERT_NOW(a_flags_excl, m_valid, !(m_is_empty && m_is_full), "Stack shown as both empty and full")
    `BSR_ASSERT_NOW(a_underflow, m_valid && (m_status == bsr_pkg::ST_UNDERFLOW), m_is_empty && (m_read_value == '0), "Underflow without an empty stack")
    `BSR_ASSERT_NOW(a_overflow, m_valid && (m_status == bsr_pkg::ST_OVERFLOW), m_is_full && (m_read_value == '0), "Overflow without a full stack")

endmodule

bind bounded_stack_with_reverse_top bsr_checker u_bsr_checker (.*);
